>>> rtl/point_line_distance_defines.svh
// ----------------------------------------------------------------------------
// Point-to-line distance: assertion macros
// Shared property forms for the checker of the distance pipeline.
// ----------------------------------------------------------------------------
`ifndef POINT_LINE_DISTANCE_DEFINES_SVH
`define POINT_LINE_DISTANCE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PLD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed delay, disabled during reset
`define PLD_ASSERT_DLY(lbl, clk, rst, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

>>> rtl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// Widths, request/result types and pipeline constants for the
// point-to-line distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

  // coordinate format
  localparam int CW     = 16;          // coordinate width
  localparam int DW     = CW + 1;      // point minus base
  localparam int PW     = DW + CW;     // d * v product
  localparam int CPW    = PW + 1;      // cross product component
  localparam int MW     = CPW - 1;     // magnitude of a cross component
  localparam int LO     = (MW + 1) / 2;
  localparam int HI     = MW - LO;
  localparam int NW     = 2 * CPW;     // |d x v|^2
  localparam int DENW   = 2 * CW;      // |v|^2
  localparam int DIST_W = 18;
  localparam int QW     = 2 * DIST_W;  // quotient bits kept
  localparam int RW     = (NW > DENW + QW) ? NW : DENW + QW;

  // clock edges from request acceptance to the result strobe (done)
  localparam int LATENCY = QW + DIST_W + 8;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] line_base_x;
    logic signed [CW-1:0] line_base_y;
    logic signed [CW-1:0] line_base_z;
    logic signed [CW-1:0] line_dir_x;
    logic signed [CW-1:0] line_dir_y;
    logic signed [CW-1:0] line_dir_z;
  } request_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              degenerate;
  } result_t;

  // control traveling alongside the data
  typedef struct packed {
    logic vld;
    logic deg;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/pld_div.sv
// ----------------------------------------------------------------------------
// pld_div
// Pipelined restoring divider, one quotient bit per stage, with the
// quotient saturated to all ones when it would not fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_div import pld_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  ctl_t            ctl_in,
  input  logic [NW-1:0]   num,
  input  logic [DENW-1:0] den,
  output ctl_t            ctl_out,
  output logic [QW-1:0]   quot
);

  logic            vld [QW+1];
  logic            deg [QW+1];
  logic            sat [QW+1];
  logic [RW-1:0]   rem [QW+1];
  logic [QW-1:0]   q   [QW+1];
  logic [DENW-1:0] dn  [QW+1];

  // entry stage: overflow check against den * 2^QW
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    deg[0] <= ctl_in.deg;
    sat[0] <= RW'(num) >= (RW'(den) << QW);
    rem[0] <= RW'(num);
    q[0]   <= '0;
    dn[0]  <= den;
  end

  // one compare and subtract per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int I = QW - 1 - k;
    logic [RW-1:0] ds;
    logic          ge;

    assign ds = RW'(dn[k]) << I;
    assign ge = rem[k] >= ds;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      deg[k+1] <= deg[k];
      sat[k+1] <= sat[k];
      rem[k+1] <= ge ? rem[k] - ds : rem[k];
      q[k+1]   <= {q[k][QW-2:0], ge};
      dn[k+1]  <= dn[k];
    end
  end

  assign ctl_out.vld = vld[QW];
  assign ctl_out.deg = deg[QW];
  assign quot        = sat[QW] ? '1 : q[QW];

endmodule

`default_nettype wire

>>> rtl/pld_sqrt.sv
// ----------------------------------------------------------------------------
// pld_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_sqrt import pld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl_in,
  input  logic [QW-1:0]     rad,
  output ctl_t              ctl_out,
  output logic [DIST_W-1:0] root
);

  localparam int TW = QW + 2;

  logic              vld [DIST_W+1];
  logic              deg [DIST_W+1];
  logic [QW-1:0]     rem [DIST_W+1];
  logic [DIST_W-1:0] r   [DIST_W+1];

  assign vld[0] = ctl_in.vld;
  assign deg[0] = ctl_in.deg;
  assign rem[0] = rad;
  assign r[0]   = '0;

  // rem holds rad - r^2; try setting bit I of the root
  for (genvar k = 0; k < DIST_W; k++) begin : g_step
    localparam int I = DIST_W - 1 - k;
    logic [TW-1:0] trial;
    logic          ge;

    assign trial = (TW'(r[k]) << (I + 1)) + (TW'(1) << (2 * I));
    assign ge    = TW'(rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      deg[k+1] <= deg[k];
      rem[k+1] <= ge ? QW'(TW'(rem[k]) - trial) : rem[k];
      r[k+1]   <= ge ? (r[k] | (DIST_W'(1) << I)) : r[k];
    end
  end

  assign ctl_out.vld = vld[DIST_W];
  assign ctl_out.deg = deg[DIST_W];
  assign root        = r[DIST_W];

endmodule

`default_nettype wire

>>> rtl/point_line_distance.sv
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the divider (one quotient bit per stage, 37 stages) and the
// square root (one root bit per stage, 18 stages) plus 7 arithmetic/output stages.
// Reset (rst, synchronous) clears every valid bit; requests in flight are dropped.
// ----------------------------------------------------------------------------
// point_line_distance
// Distance from a point to an infinite 3D line, floor(sqrt(|d x v|^2/|v|^2)).
// ----------------------------------------------------------------------------
`default_nettype none

module point_line_distance import pld_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld;

  logic signed [DW-1:0] d_x, d_y, d_z;
  logic signed [CW-1:0] v_x, v_y, v_z;
  logic signed [PW-1:0] p_a [3];
  logic signed [PW-1:0] p_b [3];
  logic [DENW-1:0]      vv  [3];
  logic [MW-1:0]        mag [3];
  logic [DENW-1:0]      den3, den4, den5;
  logic [NW-1:0]        sq  [3];
  logic [NW-1:0]        num6;
  logic [DENW-1:0]      den6;
  ctl_t                 ctl6, div_ctl, sq_ctl;
  logic [QW-1:0]        quot;
  logic [DIST_W-1:0]    root;

  assign busy = 1'b0;

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      s3_vld   <= 1'b0;
      s4_vld   <= 1'b0;
      s5_vld   <= 1'b0;
      ctl6.vld <= 1'b0;
    end else begin
      s1_vld   <= start;
      s2_vld   <= s1_vld;
      s3_vld   <= s2_vld;
      s4_vld   <= s3_vld;
      s5_vld   <= s4_vld;
      ctl6.vld <= s5_vld;
    end
  end

  // stage 1: offset of the point from the base
  always_ff @(posedge clk) begin
    d_x <= DW'(request.point_x) - DW'(request.line_base_x);
    d_y <= DW'(request.point_y) - DW'(request.line_base_y);
    d_z <= DW'(request.point_z) - DW'(request.line_base_z);
    v_x <= request.line_dir_x;
    v_y <= request.line_dir_y;
    v_z <= request.line_dir_z;
  end

  // stage 2: cross product terms and direction squares
  always_ff @(posedge clk) begin
    p_a[0] <= PW'(d_y) * PW'(v_z);
    p_b[0] <= PW'(d_z) * PW'(v_y);
    p_a[1] <= PW'(d_z) * PW'(v_x);
    p_b[1] <= PW'(d_x) * PW'(v_z);
    p_a[2] <= PW'(d_x) * PW'(v_y);
    p_b[2] <= PW'(d_y) * PW'(v_x);
    vv[0]  <= DENW'($signed(DENW'(v_x)) * $signed(DENW'(v_x)));
    vv[1]  <= DENW'($signed(DENW'(v_y)) * $signed(DENW'(v_y)));
    vv[2]  <= DENW'($signed(DENW'(v_z)) * $signed(DENW'(v_z)));
  end

  // stage 3: cross components as magnitudes, |v|^2
  for (genvar j = 0; j < 3; j++) begin : g_cross
    logic signed [CPW-1:0] c;
    assign c = CPW'(p_a[j]) - CPW'(p_b[j]);
    always_ff @(posedge clk) begin
      mag[j] <= c[CPW-1] ? MW'(-c) : MW'(c);
    end
  end

  always_ff @(posedge clk) begin
    den3 <= vv[0] + vv[1] + vv[2];
  end

  // stages 4 and 5: each square from three narrow partial products
  for (genvar j = 0; j < 3; j++) begin : g_square
    logic [2*HI-1:0]    hh;
    logic [HI+LO-1:0]   hl;
    logic [2*LO-1:0]    ll;
    logic [HI-1:0]      mh;
    logic [LO-1:0]      ml;

    assign mh = mag[j][MW-1:LO];
    assign ml = mag[j][LO-1:0];

    always_ff @(posedge clk) begin
      hh    <= mh * mh;
      hl    <= (HI+LO)'(mh) * (HI+LO)'(ml);
      ll    <= ml * ml;
      sq[j] <= (NW'(hh) << (2 * LO)) + (NW'(hl) << (LO + 1)) + NW'(ll);
    end
  end

  always_ff @(posedge clk) begin
    den4 <= den3;
    den5 <= den4;
  end

  // stage 6: |d x v|^2 and zero-direction check
  always_ff @(posedge clk) begin
    num6     <= sq[0] + sq[1] + sq[2];
    den6     <= den5;
    ctl6.deg <= den5 == '0;
  end

  pld_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl6),
    .num     (num6),
    .den     (den6),
    .ctl_out (div_ctl),
    .quot    (quot)
  );

  pld_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (div_ctl),
    .rad     (quot),
    .ctl_out (sq_ctl),
    .root    (root)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    result.distance   <= sq_ctl.deg ? '0 : root;
    result.degenerate <= sq_ctl.deg;
  end

endmodule

`default_nettype wire

>>> rtl/pld_checker.sv
// ----------------------------------------------------------------------------
// pld_checker
// Port-level checks of the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_line_distance_defines.svh"

module pld_checker import pld_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input request_t request,
  input logic     done,
  input result_t  result
);

  logic dir_zero;
  logic on_line;

  assign dir_zero = (request.line_dir_x == '0) && (request.line_dir_y == '0) &&
                    (request.line_dir_z == '0);
  assign on_line  = (request.point_x == request.line_base_x) &&
                    (request.point_y == request.line_base_y) &&
                    (request.point_z == request.line_base_z);

  // a degenerate line reports zero distance
  `PLD_ASSERT_IMP(a_deg_dist, clk, rst, done && result.degenerate, result.distance == '0, "degenerate result with nonzero distance")

  // every result traces back to a request a fixed latency earlier
  `PLD_ASSERT_IMP(a_done_src, clk, rst, done, $past(start && !busy, LATENCY), "result without a matching request")

  // a zero direction comes out flagged
  `PLD_ASSERT_DLY(a_deg_flag, clk, rst, start && !busy && dir_zero, LATENCY, done && result.degenerate, "zero direction not flagged")

  // a point on the line is at distance zero
  `PLD_ASSERT_DLY(a_on_line, clk, rst, start && !busy && on_line, LATENCY, done && (result.distance == '0), "point on line gave nonzero distance")

endmodule

bind point_line_distance pld_checker u_pld_checker (.*);

`default_nettype wire
